/* src/offset_ordered_block_allocator_top_defines.svh */
// Assertion macros shared by the allocator RTL.
`ifndef OFFSET_ORDERED_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define OFFSET_ORDERED_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property while out of reset.
`define OFFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define OFFB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OFFB_ASSERT(label, clk, rst_n, prop, msg)
`define OFFB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* src/offb_pkg.sv */
// Shared constants and types of the offset ordered block allocator.
package offb_pkg;
  localparam int MaxRecordsDef = 64;
  localparam int HeaderBytesDef = 16;
  localparam logic [20:0] ChunkLimit = 21'd1048576;
  localparam logic [20:0] ChunkReset = 21'd65536;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoGap    = 3'd1,
    StSize     = 3'd2,
    StNotFound = 3'd3,
    StFull     = 3'd4
  } status_e;

  // Command broadcast to every cell of the record chain.
  typedef struct packed {
    logic        ins;
    logic        rem;
    logic [21:0] size;
    logic [19:0] new_start;
    logic [20:0] rel_off;
  } cell_cmd_t;
endpackage

/* src/offb_cell.sv */
// One record cell of the sorted allocation chain.
`include "offset_ordered_block_allocator_top_defines.svh"
module offb_cell #(
  parameter int MAX_RECORDS  = offb_pkg::MaxRecordsDef,
  parameter int HEADER_BYTES = offb_pkg::HeaderBytesDef,
  parameter int IDX          = 0,
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  offb_pkg::cell_cmd_t cmd_i,
  input  logic [CW-1:0]       pos_i,
  input  logic                is_top_i,
  input  logic [20:0]         chunk_top_i,
  input  logic [19:0]         below_start_i,
  input  logic [20:0]         below_len_i,
  input  logic [19:0]         above_start_i,
  input  logic [20:0]         above_len_i,
  output logic [19:0]         start_o,
  output logic [20:0]         len_o,
  output logic [21:0]         rtop_o,
  output logic                fit_o,
  output logic                match_o
);
  logic [19:0] start_q, start_d;
  logic [20:0] len_q, len_d;
  logic [20:0] top_end;
  logic        above_pos, at_pos;

  assign above_pos = CW'(IDX) > pos_i;
  assign at_pos    = CW'(IDX) == pos_i;

  // Shift toward the top on insert, toward the bottom on remove.
  always_comb begin
    start_d = start_q;
    len_d   = len_q;
    if (cmd_i.ins && above_pos) begin
      start_d = below_start_i;
      len_d   = below_len_i;
    end else if (cmd_i.ins && at_pos) begin
      start_d = cmd_i.new_start;
      len_d   = cmd_i.size[20:0];
    end else if (cmd_i.rem && (above_pos || at_pos)) begin
      start_d = above_start_i;
      len_d   = above_len_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      len_q   <= '0;
    end else begin
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  // Gap above this record and the free lookup.
  assign rtop_o  = {2'b0, start_q} + {1'b0, len_q};
  assign top_end = is_top_i ? chunk_top_i : {1'b0, above_start_i};
  assign fit_o   = {2'b0, top_end} >= ({1'b0, cmd_i.size} + {1'b0, rtop_o});
  assign match_o = ({2'b0, start_q} + 22'(HEADER_BYTES)) == {1'b0, cmd_i.rel_off};
  assign start_o = start_q;
  assign len_o   = len_q;

  `OFFB_ASSERT(a_no_ins_rem, clk_i, rst_ni, !(cmd_i.ins && cmd_i.rem), "insert and remove together")
  `OFFB_ASSERT(a_hold, clk_i, rst_ni, (!cmd_i.ins && !cmd_i.rem) |=> $stable(start_q) && $stable(len_q), "cell changed without command")
  `OFFB_ASSERT(a_ins_load, clk_i, rst_ni, (cmd_i.ins && at_pos) |=> start_q == $past(cmd_i.new_start), "insert not loaded")
endmodule

/* src/offset_ordered_block_allocator_top.sv */
// Top level of the offset ordered block allocator.
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid_i/in_stall_o  | action, request_bytes, release_offset
//  out     | source    | out_valid_o/out_stall_i| status, user_offset, bytes_in_use
//  cfg     | sink      | cfg_we_i               | chunk_bytes
//
// An allocate scans one record cell per cycle from the highest record down.
// A free steps upward through the cells from the lowest record.
// Insert and remove shift the cell chain in the commit cycle.
// Reset clears all cells, the count and the total; chunk_bytes resets to 65536.
// A result waits in the output register; a stalled output holds the commit.
`include "offset_ordered_block_allocator_top_defines.svh"
module offset_ordered_block_allocator_top #(
  parameter int MAX_RECORDS  = offb_pkg::MaxRecordsDef,
  parameter int HEADER_BYTES = offb_pkg::HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [20:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [20:0] request_bytes_i,
  input  logic [20:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [20:0] user_offset_o,
  output logic [20:0] bytes_in_use_o
);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic        state_q, state_d;
  logic [20:0] chunk_q;
  logic        act_q;
  logic [21:0] size_q;
  logic [20:0] rel_q;
  logic [CW-1:0] i_q, i_d, count_q, sel;
  logic [20:0] total_q;
  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [20:0] uoff_q;

  logic [19:0] starts [MAX_RECORDS];
  logic [20:0] lens   [MAX_RECORDS];
  logic [21:0] rtops  [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] fits, match_vec;
  logic [21:0] rtop_sel;
  logic [20:0] len_sel;
  logic        hit_fit, hit_match;
  logic [20:0] chunk_top, top0;
  offb_pkg::cell_cmd_t cmd;
  logic        done, ins, rem, accept, commit;
  offb_pkg::status_e st;
  logic [20:0] uoff;

  assign chunk_top = (chunk_q > offb_pkg::ChunkLimit) ? offb_pkg::ChunkLimit : chunk_q;
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign sel = (act_q == offb_pkg::ActAlloc) ? (i_q - CW'(1)) : i_q;

  // Cell chain.
  for (genvar j = 0; j < MAX_RECORDS; j++) begin : g_cell
    logic [19:0] bs, as;
    logic [20:0] bl, al;
    if (j == 0) begin : g_bot
      assign bs = '0;
      assign bl = '0;
    end else begin : g_mid
      assign bs = starts[j-1];
      assign bl = lens[j-1];
    end
    if (j == MAX_RECORDS - 1) begin : g_top
      assign as = '0;
      assign al = '0;
    end else begin : g_low
      assign as = starts[j+1];
      assign al = lens[j+1];
    end
    offb_cell #(
      .MAX_RECORDS(MAX_RECORDS), .HEADER_BYTES(HEADER_BYTES), .IDX(j)
    ) u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .pos_i(i_q),
      .is_top_i(CW'(j) == (count_q - CW'(1))), .chunk_top_i(chunk_top),
      .below_start_i(bs), .below_len_i(bl), .above_start_i(as), .above_len_i(al),
      .start_o(starts[j]), .len_o(lens[j]), .rtop_o(rtops[j]),
      .fit_o(fits[j]), .match_o(match_vec[j])
    );
  end

  // Pick the cell under the scan index.
  always_comb begin
    hit_fit = 1'b0;
    hit_match = 1'b0;
    rtop_sel = '0;
    len_sel = '0;
    for (int j = 0; j < MAX_RECORDS; j++) begin
      if (sel == CW'(j)) begin
        hit_fit   = hit_fit | fits[j];
        hit_match = hit_match | match_vec[j];
        rtop_sel  = rtop_sel | rtops[j];
        len_sel   = len_sel | lens[j];
      end
    end
  end

  assign top0 = (count_q == '0) ? chunk_top : {1'b0, starts[0]};

  // Scan step and result.
  always_comb begin
    done = 1'b0;
    st   = offb_pkg::StOk;
    uoff = '0;
    ins  = 1'b0;
    rem  = 1'b0;
    i_d  = i_q;
    if (act_q == offb_pkg::ActAlloc) begin
      if (size_q == '0 || size_q > {1'b0, chunk_top}) begin
        done = 1'b1;
        st = offb_pkg::StSize;
      end else if (count_q >= CW'(MAX_RECORDS)) begin
        done = 1'b1;
        st = offb_pkg::StFull;
      end else if (i_q == '0) begin
        done = 1'b1;
        if ({1'b0, top0} >= size_q) begin
          ins = 1'b1;
          uoff = 21'(HEADER_BYTES);
        end else begin
          st = offb_pkg::StNoGap;
        end
      end else if (hit_fit) begin
        done = 1'b1;
        ins = 1'b1;
        uoff = 21'(rtop_sel + 22'(HEADER_BYTES));
      end else begin
        i_d = i_q - CW'(1);
      end
    end else begin
      if (i_q == count_q) begin
        done = 1'b1;
        st = offb_pkg::StNotFound;
      end else if (hit_match) begin
        done = 1'b1;
        rem = 1'b1;
      end else begin
        i_d = i_q + CW'(1);
      end
    end
  end

  assign commit = (state_q == ST_SCAN) && done && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd.ins       = commit && ins;
    cmd.rem       = commit && rem;
    cmd.size      = size_q;
    cmd.new_start = (i_q == '0) ? 20'd0 : rtop_sel[19:0];
    cmd.rel_off   = rel_q;
  end

  always_comb begin
    state_d = state_q;
    if (accept) state_d = ST_SCAN;
    else if (commit) state_d = ST_IDLE;
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= offb_pkg::ChunkReset;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) chunk_q <= cfg_wdata_i;
      if (accept) begin
        i_q <= (action_i == offb_pkg::ActAlloc) ? count_q : '0;
      end else if (state_q == ST_SCAN && !done) begin
        i_q <= i_d;
      end
      if (cmd.ins) begin
        count_q <= count_q + CW'(1);
        total_q <= total_q + size_q[20:0];
      end else if (cmd.rem) begin
        count_q <= count_q - CW'(1);
        total_q <= total_q - len_sel;
      end
      if (commit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Transaction payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= action_i;
      size_q <= {1'b0, request_bytes_i} + 22'(HEADER_BYTES);
      rel_q  <= release_offset_i;
    end
    if (commit) begin
      status_q <= st;
      uoff_q   <= uoff;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign user_offset_o  = uoff_q;
  assign bytes_in_use_o = total_q;

  `OFFB_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CW'(MAX_RECORDS), "record count overflow")
  `OFFB_ASSERT(a_ins_count, clk_i, rst_ni, cmd.ins |=> count_q == $past(count_q) + CW'(1), "insert did not grow count")
  `OFFB_ASSERT(a_commit_out, clk_i, rst_ni, commit |=> out_valid_q, "commit lost result")
endmodule
